// ===== rtl/i2cram_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// i2cram_pkg
// Shared types and constants for the I2C register access master.
// ---------------------------------------------------------------------------
package i2cram_pkg;

  localparam int unsigned HB_W    = 16;
  localparam int unsigned RETRY_W = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BITCNT_W = 4;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 16;

  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = BITCNT_W'(8);
  localparam logic [HB_W-1:0] HB_RESET = HB_W'(1);
  localparam logic [RETRY_W-1:0] RETRY_RESET = RETRY_W'(250);

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_HALF_BIT_TICKS  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACK_RETRY_LIMIT = 1'b1;

  // Command codes
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Sub-step within a bus phase
  localparam logic [1:0] STEP_FIRST  = 2'd0;
  localparam logic [1:0] STEP_SECOND = 2'd1;
  localparam logic [1:0] STEP_THIRD  = 2'd2;

  typedef enum logic [14:0] {
    PH_IDLE     = 15'b000000000000001,
    PH_START    = 15'b000000000000010,
    PH_WR_DEV   = 15'b000000000000100,
    PH_ACK_DEV  = 15'b000000000001000,
    PH_WR_REG   = 15'b000000000010000,
    PH_ACK_REG  = 15'b000000000100000,
    PH_WR_DATA  = 15'b000000001000000,
    PH_ACK_DATA = 15'b000000010000000,
    PH_RESTART  = 15'b000000100000000,
    PH_WR_DEVR  = 15'b000001000000000,
    PH_ACK_DEVR = 15'b000010000000000,
    PH_READ     = 15'b000100000000000,
    PH_NACK     = 15'b001000000000000,
    PH_STOP     = 15'b010000000000000,
    PH_FINISH   = 15'b100000000000000
  } phase_t;

  typedef struct packed {
    logic [HB_W-1:0]    half_bit_ticks;
    logic [RETRY_W-1:0] ack_retry_limit;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [1:0]          step;
    logic [BITCNT_W-1:0] bit_count;
    logic [HB_W-1:0]     delay_count;
    logic [RETRY_W-1:0]  retry_count;
    logic [BYTE_W-1:0]   shift_byte;
    logic [BYTE_W-1:0]   dev_addr;
    logic [BYTE_W-1:0]   reg_addr;
    logic [BYTE_W-1:0]   wr_data;
    logic                is_read;
    logic [BYTE_W-1:0]   read_byte;
    logic                error_flag;
    logic                scl;
    logic                sda;
    logic                oe;
  } bus_state_t;

  // Sequencer state after reset: idle, with both lines driven high.
  localparam bus_state_t BUS_STATE_RESET = '{
    phase:       PH_IDLE,
    step:        STEP_FIRST,
    bit_count:   '0,
    delay_count: '0,
    retry_count: '0,
    shift_byte:  '0,
    dev_addr:    '0,
    reg_addr:    '0,
    wr_data:     '0,
    is_read:     1'b0,
    read_byte:   '0,
    error_flag:  1'b0,
    scl:         1'b1,
    sda:         1'b1,
    oe:          1'b1
  };

  typedef struct packed {
    logic                cmd_write;
    logic                cmd_read;
    logic [BYTE_W-1:0]   dev_addr;
    logic [BYTE_W-1:0]   reg_addr;
    logic [BYTE_W-1:0]   wr_data;
    logic                sda_in;
  } tick_in_t;

endpackage

`default_nettype wire

// ===== rtl/i2cram_cfg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// i2cram_cfg
// Configuration registers, with the bus step length clamped to at least one tick.
// ---------------------------------------------------------------------------
module i2cram_cfg
  import i2cram_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg,
  output logic [HB_W-1:0]            hold_ticks
);

  logic [HB_W-1:0]    half_bit_ticks;
  logic [RETRY_W-1:0] ack_retry_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_ticks  <= HB_RESET;
      ack_retry_limit <= RETRY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_HALF_BIT_TICKS:  half_bit_ticks  <= cfg_wdata[HB_W-1:0];
        CFG_ACK_RETRY_LIMIT: ack_retry_limit <= cfg_wdata[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{half_bit_ticks: half_bit_ticks, ack_retry_limit: ack_retry_limit};

  // Reload value of the delay counter: a zero step length behaves as one tick.
  assign hold_ticks = (half_bit_ticks == '0) ? '0 : half_bit_ticks - HB_W'(1);

endmodule

`default_nettype wire

// ===== rtl/i2cram_seq.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// i2cram_seq
// Next-state logic of the bus sequencer for one tick.
// ---------------------------------------------------------------------------
module i2cram_seq
  import i2cram_pkg::*;
(
  input  wire bus_state_t st,
  input  wire tick_in_t   tin,
  input  wire cfg_t       cfg,
  input  wire logic [HB_W-1:0] hold_ticks,
  output bus_state_t      st_next,
  output logic            done
);

  bus_state_t          base;
  bus_state_t          act;
  logic                act_done;
  logic                start_cmd;
  logic [BITCNT_W-1:0] bc_inc;

  function automatic bus_state_t go_phase(bus_state_t s, phase_t p);
    bus_state_t r;
    r = s;
    r.phase = p;
    r.step = STEP_FIRST;
    r.bit_count = '0;
    if (p == PH_WR_DEV) r.shift_byte = s.dev_addr;
    else if (p == PH_WR_REG) r.shift_byte = s.reg_addr;
    else if (p == PH_WR_DATA) r.shift_byte = s.wr_data;
    else if (p == PH_WR_DEVR) r.shift_byte = s.dev_addr | BYTE_W'(1);
    return r;
  endfunction

  always_comb begin
    start_cmd = tin.cmd_write | tin.cmd_read;
    base = st;
    if (st.phase == PH_IDLE && start_cmd) begin
      base.dev_addr    = tin.dev_addr;
      base.reg_addr    = tin.reg_addr;
      base.wr_data     = tin.wr_data;
      base.is_read     = tin.cmd_read;
      base.error_flag  = 1'b0;
      base.retry_count = '0;
      base = go_phase(base, PH_START);
    end

    act = base;
    act_done = 1'b0;
    bc_inc = base.bit_count + BITCNT_W'(1);

    unique case (base.phase)
      PH_IDLE: ;
      PH_START, PH_RESTART: begin
        if (base.step == STEP_FIRST) begin
          act.oe = 1'b1; act.sda = 1'b1; act.scl = 1'b1; act.step = STEP_SECOND;
        end else if (base.step == STEP_SECOND) begin
          act.sda = 1'b0; act.step = STEP_THIRD;
        end else begin
          act.scl = 1'b0;
          act = go_phase(act, (base.phase == PH_START) ? PH_WR_DEV : PH_WR_DEVR);
        end
        act.delay_count = hold_ticks;
      end
      PH_WR_DEV, PH_WR_REG, PH_WR_DATA, PH_WR_DEVR: begin
        if (base.step == STEP_FIRST) begin
          act.oe = 1'b1; act.scl = 1'b0; act.step = STEP_SECOND;
        end else if (base.step == STEP_SECOND) begin
          act.sda = base.shift_byte[BYTE_W-1]; act.step = STEP_THIRD;
        end else begin
          act.scl = 1'b1;
          act.shift_byte = {base.shift_byte[BYTE_W-2:0], 1'b0};
          act.bit_count = bc_inc;
          if (bc_inc >= BITS_PER_BYTE) begin
            unique case (base.phase)
              PH_WR_DEV:  act = go_phase(act, PH_ACK_DEV);
              PH_WR_REG:  act = go_phase(act, PH_ACK_REG);
              PH_WR_DATA: act = go_phase(act, PH_ACK_DATA);
              default:    act = go_phase(act, PH_ACK_DEVR);
            endcase
          end else begin
            act.step = STEP_FIRST;
          end
        end
        act.delay_count = hold_ticks;
      end
      PH_ACK_DEV, PH_ACK_REG, PH_ACK_DATA, PH_ACK_DEVR: begin
        if (base.step == STEP_FIRST) begin
          act.scl = 1'b0; act.sda = 1'b1; act.oe = 1'b0;
          act.retry_count = '0; act.step = STEP_SECOND;
          act.delay_count = hold_ticks;
        end else if (base.step == STEP_SECOND) begin
          act.scl = 1'b1; act.step = STEP_THIRD;
          act.delay_count = hold_ticks;
        end else if (!tin.sda_in) begin
          act.scl = 1'b0;
          unique case (base.phase)
            PH_ACK_DEV:  act = go_phase(act, PH_WR_REG);
            PH_ACK_REG:  act = go_phase(act, base.is_read ? PH_RESTART : PH_WR_DATA);
            PH_ACK_DATA: act = go_phase(act, PH_STOP);
            default:     act = go_phase(act, PH_READ);
          endcase
          act.delay_count = hold_ticks;
        end else if (base.retry_count >= cfg.ack_retry_limit) begin
          // Timeout: abort and start the STOP sequence on this same tick.
          act.error_flag = 1'b1;
          act = go_phase(act, PH_STOP);
          act.oe = 1'b1; act.sda = 1'b0; act.step = STEP_SECOND;
          act.delay_count = hold_ticks;
        end else begin
          act.retry_count = base.retry_count + RETRY_W'(1);
        end
      end
      PH_READ: begin
        if (base.step == STEP_FIRST) begin
          act.oe = 1'b0; act.scl = 1'b1; act.step = STEP_SECOND;
        end else begin
          act.shift_byte = {base.shift_byte[BYTE_W-2:0], tin.sda_in};
          act.scl = 1'b0;
          act.bit_count = bc_inc;
          if (bc_inc >= BITS_PER_BYTE) act = go_phase(act, PH_NACK);
          else act.step = STEP_FIRST;
        end
        act.delay_count = hold_ticks;
      end
      PH_NACK: begin
        if (base.step == STEP_FIRST) begin
          act.oe = 1'b1; act.sda = 1'b1; act.step = STEP_SECOND;
        end else if (base.step == STEP_SECOND) begin
          act.scl = 1'b1; act.step = STEP_THIRD;
        end else begin
          act.scl = 1'b0;
          act = go_phase(act, PH_STOP);
        end
        act.delay_count = hold_ticks;
      end
      PH_STOP: begin
        if (base.step == STEP_FIRST) begin
          act.oe = 1'b1; act.sda = 1'b0; act.step = STEP_SECOND;
        end else if (base.step == STEP_SECOND) begin
          act.scl = 1'b1; act.step = STEP_THIRD;
        end else begin
          act.sda = 1'b1;
          act = go_phase(act, PH_FINISH);
        end
        act.delay_count = hold_ticks;
      end
      PH_FINISH: begin
        if (base.is_read && !base.error_flag) act.read_byte = base.shift_byte;
        act = go_phase(act, PH_IDLE);
        act_done = 1'b1;
      end
      default: act = go_phase(act, PH_IDLE);
    endcase

    st_next = st;
    done = 1'b0;
    if (st.phase == PH_IDLE) begin
      if (start_cmd) begin
        st_next = act;
        done = act_done;
      end
    end else if (st.delay_count != '0) begin
      st_next.delay_count = st.delay_count - HB_W'(1);
    end else begin
      st_next = act;
      done = act_done;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2c_register_access_master.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// i2c_register_access_master
// Pin-level I2C master for single-byte register writes and reads.
//
//   channel  | direction | contents
//   s_axis   | in        | one bus tick: command, addresses, write data, SDA
//   m_axis   | out       | line levels and status for that tick
//   cfg      | in        | step length and ACK retry limit, write only
//
// Every request is one bus tick and yields exactly one result request.
// A request is taken every cycle while the result register can accept it;
// its result is registered together with the sequencer state and shows in the next cycle.
// Reset is synchronous and returns the bus to idle with both lines high.
// When the result register is full and not taken, new requests are held off.
// ---------------------------------------------------------------------------
module i2c_register_access_master
  import i2cram_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [7:0] dev_addr, [15:8] reg_addr, [23:16] wr_data, [24] sda_in, rest zero
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  // [1:0] cmd
  input  wire logic [S_TUSER_W-1:0]  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [0] scl, [1] sda_out, [2] sda_oe, [3] busy_res, [4] done_res,
  // [12:5] rd_data, [13] ack_error, rest zero
  output logic [M_TDATA_W-1:0]       m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t             cfg;
  logic [HB_W-1:0]  hold_ticks;
  tick_in_t         tin;
  bus_state_t       st;
  bus_state_t       st_next;
  logic             done;
  logic             take;
  logic [M_TDATA_W-1:0] result;

  i2cram_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cfg        (cfg),
    .hold_ticks (hold_ticks)
  );

  assign tin = '{
    cmd_write: (s_tuser == CMD_WRITE),
    cmd_read:  (s_tuser == CMD_READ),
    dev_addr:  s_tdata[7:0],
    reg_addr:  s_tdata[15:8],
    wr_data:   s_tdata[23:16],
    sda_in:    s_tdata[24]
  };

  i2cram_seq u_seq (
    .st         (st),
    .tin        (tin),
    .cfg        (cfg),
    .hold_ticks (hold_ticks),
    .st_next    (st_next),
    .done       (done)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  assign result = {2'b00, st_next.error_flag, st_next.read_byte, done,
                   (st_next.phase != PH_IDLE), st_next.oe, st_next.sda, st_next.scl};

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= BUS_STATE_RESET;
      m_tvalid    <= 1'b0;
      m_tdata     <= '0;
    end else begin
      if (take) begin
        st       <= st_next;
        m_tdata  <= result;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2cram_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// i2cram_checker
// Port-level checks on the I2C register access master.
// ---------------------------------------------------------------------------
module i2cram_checker
  import i2cram_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tready,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  // No result request may appear straight out of reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result request keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // A ready sink must never hold off new requests.
  a_flow: assert property (@(posedge clk) disable iff (rst) m_tready |-> s_tready)
    else $error("input stalled while output drains");

  // The finishing tick reports the bus as no longer busy.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> !m_tdata[3])
    else $error("done while still busy");

  // SDA is released only with the driven level high.
  a_release_high: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[1])
    else $error("SDA released with low level");

endmodule

bind i2c_register_access_master i2cram_checker u_i2cram_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
